/* rtl/srth_pkg.sv */
`timescale 1ns / 1ps

package srth_pkg;

    typedef enum logic [1:0] {
        ACT_BYTE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_UP   = 2'd2,
        ACT_DOWN = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WAIT      = 2'd1,
        CFG_MODE      = 2'd2
    } cfg_index_t;

    localparam logic [15:0] RUN_MAX  = 16'hFFFF;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    localparam logic [15:0] THRESHOLD_RESET = 16'd20;
    localparam logic [15:0] WAIT_RESET      = 16'd5;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_QUEST = 8'h3F;

    typedef struct packed {
        logic is_text;
        logic is_space;
        logic is_punct;
        logic is_vowel;
    } byte_class_t;

    typedef struct packed {
        logic [15:0] text_threshold;
        logic [15:0] wait_ticks;
        logic        manual_mode;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  rate_index;
        logic        rate_changed;
        logic        locked;
        logic [15:0] text_run;
    } result_t;

endpackage

/* rtl/srth_classify.sv */
`timescale 1ns / 1ps

module srth_classify
    import srth_pkg::*;
(
    input  logic [7:0]  rx_byte,
    output byte_class_t byte_class
);

    always_comb begin
        byte_class.is_text  = (rx_byte inside {[CHAR_SPACE:CHAR_TILDE]}) ||
                              rx_byte == CHAR_LF || rx_byte == CHAR_CR;
        byte_class.is_space = rx_byte inside {CHAR_SPACE, CHAR_CR, CHAR_LF};
        byte_class.is_punct = rx_byte inside {CHAR_DOT, CHAR_COMMA, CHAR_SEMI,
                                              CHAR_COLON, CHAR_BANG, CHAR_QUEST};
        byte_class.is_vowel = rx_byte inside {"a", "e", "i", "o", "u",
                                              "A", "E", "I", "O", "U"};
    end

endmodule

/* rtl/srth_core.sv */
`timescale 1ns / 1ps

module srth_core
    import srth_pkg::*;
#(
    parameter int NUM_RATES    = 16,
    parameter int DEFAULT_RATE = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  action_t     action,
    input  logic [7:0]  rx_byte,
    input  cfg_t        cfg,
    output result_t     result
);

    localparam int IDX_W = $clog2(NUM_RATES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RATES - 1);
    localparam logic [IDX_W-1:0] DEF_IDX  =
        (DEFAULT_RATE < NUM_RATES) ? IDX_W'(DEFAULT_RATE) : IDX_W'(NUM_RATES - 1);

    logic [IDX_W-1:0] rate_idx_reg, rate_idx_next;
    logic [15:0]      run_count_reg, run_count_next;
    logic             saw_space_reg, saw_space_next;
    logic             saw_punct_reg, saw_punct_next;
    logic             saw_vowel_reg, saw_vowel_next;
    logic [15:0]      tick_count_reg, tick_count_next;
    logic             clear_pending_reg, clear_pending_next;
    logic             lock_reg, lock_next;

    byte_class_t      byte_class;
    logic [15:0]      tick_inc;
    logic [IDX_W-1:0] idx_up;
    logic [IDX_W-1:0] idx_down;

    srth_classify u_classify (
        .rx_byte    (rx_byte),
        .byte_class (byte_class)
    );

    assign idx_up   = (rate_idx_reg == LAST_IDX) ? '0 : rate_idx_reg + 1'b1;
    assign idx_down = (rate_idx_reg == '0) ? DEF_IDX : rate_idx_reg - 1'b1;
    assign tick_inc = (tick_count_reg == TICK_MAX) ? tick_count_reg : tick_count_reg + 16'd1;

    always_comb begin
        rate_idx_next      = rate_idx_reg;
        run_count_next     = run_count_reg;
        saw_space_next     = saw_space_reg;
        saw_punct_next     = saw_punct_reg;
        saw_vowel_next     = saw_vowel_reg;
        tick_count_next    = tick_count_reg;
        clear_pending_next = clear_pending_reg;
        lock_next          = lock_reg;

        if (!lock_reg) begin
            if (cfg.manual_mode) begin
                case (action)
                    ACT_UP:   rate_idx_next = idx_up;
                    ACT_DOWN: rate_idx_next = idx_down;
                    default:  ;
                endcase
            end else begin
                case (action)
                    ACT_BYTE: begin
                        if (byte_class.is_text) begin
                            if (run_count_reg != RUN_MAX)
                                run_count_next = run_count_reg + 16'd1;
                            saw_space_next = saw_space_reg | byte_class.is_space;
                            saw_punct_next = saw_punct_reg | byte_class.is_punct;
                            saw_vowel_next = saw_vowel_reg | byte_class.is_vowel;
                        end else begin
                            run_count_next = '0;
                            saw_space_next = 1'b0;
                            saw_punct_next = 1'b0;
                            saw_vowel_next = 1'b0;
                        end
                        if (run_count_next >= cfg.text_threshold && saw_space_next &&
                            saw_punct_next && saw_vowel_next) begin
                            lock_next = 1'b1;
                        end else if (clear_pending_reg) begin
                            // drop the run gathered at the previous rate
                            clear_pending_next = 1'b0;
                            run_count_next     = '0;
                            saw_space_next     = 1'b0;
                            saw_punct_next     = 1'b0;
                            saw_vowel_next     = 1'b0;
                        end
                    end
                    ACT_TICK: begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= cfg.wait_ticks) begin
                            tick_count_next    = '0;
                            clear_pending_next = 1'b1;
                            rate_idx_next      = idx_down;
                        end
                    end
                    default: ;
                endcase
            end
        end

        result.rate_index   = 4'(rate_idx_next);
        result.rate_changed = (rate_idx_next != rate_idx_reg);
        result.locked       = lock_next;
        result.text_run     = run_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_idx_reg      <= DEF_IDX;
            run_count_reg     <= '0;
            saw_space_reg     <= 1'b0;
            saw_punct_reg     <= 1'b0;
            saw_vowel_reg     <= 1'b0;
            tick_count_reg    <= '0;
            clear_pending_reg <= 1'b0;
            lock_reg          <= 1'b0;
        end else if (en) begin
            rate_idx_reg      <= rate_idx_next;
            run_count_reg     <= run_count_next;
            saw_space_reg     <= saw_space_next;
            saw_punct_reg     <= saw_punct_next;
            saw_vowel_reg     <= saw_vowel_next;
            tick_count_reg    <= tick_count_next;
            clear_pending_reg <= clear_pending_next;
            lock_reg          <= lock_next;
        end
    end

`ifndef SYNTHESIS
    a_lock_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        lock_reg |=> lock_reg)
        else $error("lock dropped without reset");

    a_locked_rate_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        lock_reg |=> $stable(rate_idx_reg))
        else $error("rate index moved while locked");

    a_rate_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rate_idx_reg <= LAST_IDX)
        else $error("rate index beyond table");

    a_manual_run_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.manual_mode |=> $stable(run_count_reg) && $stable(tick_count_reg))
        else $error("text run or tick count moved in manual mode");
`endif

endmodule

/* rtl/serial_rate_text_hunter.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_action, s_rx_byte
// m_        out        m_valid / m_ready    m_rate_index, m_rate_changed, m_locked, m_text_run
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An input beat passes through the input register, then through the state update
// into the result register, from which its result beat is offered.
// One beat per cycle is sustained while m_ready stays high. Reset is synchronous,
// active low, and returns all registers but the data registers (action, byte, result) to their defaults.
// A stalled result holds the result register; the input register still takes
// one more beat, then s_ready drops until the result is taken.
module serial_rate_text_hunter
    import srth_pkg::*;
#(
    parameter int NUM_RATES    = 16,
    parameter int DEFAULT_RATE = 15
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_rate_index,
    output logic        m_rate_changed,
    output logic        m_locked,
    output logic [15:0] m_text_run,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg;
    action_t     action_reg;
    logic [7:0]  byte_reg;
    logic        m_valid_reg;
    result_t     result_reg;
    result_t     result;
    cfg_t        cfg_reg;
    logic        advance;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.text_threshold <= THRESHOLD_RESET;
            cfg_reg.wait_ticks     <= WAIT_RESET;
            cfg_reg.manual_mode    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: cfg_reg.text_threshold <= cfg_data;
                CFG_WAIT:      cfg_reg.wait_ticks     <= cfg_data;
                CFG_MODE:      cfg_reg.manual_mode    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= action_t'(s_action);
            byte_reg   <= s_rx_byte;
        end
    end

    srth_core #(
        .NUM_RATES    (NUM_RATES),
        .DEFAULT_RATE (DEFAULT_RATE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .action  (action_reg),
        .rx_byte (byte_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_rate_index   = result_reg.rate_index;
    assign m_rate_changed = result_reg.rate_changed;
    assign m_locked       = result_reg.locked;
    assign m_text_run     = result_reg.text_run;

endmodule
